// ===== design/ppb_pkg.sv =====
// Package for the plasma pixel blender: constants, codes, sine and blend functions.
`default_nettype none

package ppb_pkg;

    localparam int MAX_DIMENSION_DEF    = 4096;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [15:0] RAMP_T1  = 16'd21627;
    localparam logic [15:0] RAMP_T2  = 16'd43254;
    localparam logic [16:0] BLEND_80 = 17'd52429;

    localparam logic [23:0] COL_BLUE   = 24'h0000FF;
    localparam logic [23:0] COL_CYAN   = 24'h00FFFF;
    localparam logic [23:0] COL_YELLOW = 24'hFFFF00;
    localparam logic [23:0] COL_RED    = 24'hFF0000;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_TIME   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEG_LOW  = 2'd0,
        SEG_MID  = 2'd1,
        SEG_HIGH = 2'd2
    } t_ramp_seg;

    // Sine of a phase given as a 32-bit fraction of a full turn, Q1.15,
    // by a Q30 Taylor series with quarter-wave folding.
    function automatic logic signed [15:0] sine_q15(input logic [63:0] frac);
        logic [63:0] f;
        logic        neg;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] e;
        f   = frac;
        neg = 1'b0;
        if (f >= 64'h8000_0000) begin
            neg = 1'b1;
            f   = f - 64'h8000_0000;
        end
        if (f > 64'h4000_0000) begin
            f = 64'h8000_0000 - f;
        end
        a    = (f * TWO_PI_Q30) >> 32;
        a2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        term = ((term * a2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        e = (($unsigned(sum) << 15) + 64'h2000_0000) >> 30;
        if (e > 64'd32767) begin
            e = 64'd32767;
        end
        return neg ? -$signed(16'(e)) : $signed(16'(e));
    endfunction

    // One 8-bit channel of a blend from a to b by fraction f (Q0.16, up to 1.0).
    function automatic logic [7:0] blend_ch(input logic [7:0] ca, input logic [7:0] cb,
                                            input logic [16:0] f);
        logic [25:0] acc;
        acc = 26'(ca) * 26'(ONE_Q16 - f) + 26'(cb) * 26'(f);
        return acc[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== design/ppb_div.sv =====
// Pipelined restoring divider: saturated floor(num * 2^16 / den), one bit per stage.
`default_nettype none

module ppb_div
    import ppb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [11:0] i_num,
    input  wire logic [12:0] i_den,
    output logic      [15:0] o_quot
);

    localparam int STEPS = 16;

    logic [12:0] r_rem  [1:STEPS];
    logic [15:0] r_quot [1:STEPS];
    logic        r_sat  [1:STEPS];

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [12:0] w_rem_in;
        logic [15:0] w_quot_in;
        logic        w_sat_in;
        logic [13:0] w_shift;
        logic        w_ge;
        if (k == 1) begin : g_first
            assign w_rem_in  = {1'b0, i_num};
            assign w_quot_in = '0;
            assign w_sat_in  = ({1'b0, i_num} >= i_den);
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_quot_in = r_quot[k-1];
            assign w_sat_in  = r_sat[k-1];
        end
        assign w_shift = {w_rem_in, 1'b0};
        assign w_ge    = (w_shift >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? 13'(w_shift - {1'b0, i_den}) : w_shift[12:0];
                r_quot[k] <= {w_quot_in[14:0], w_ge};
                r_sat[k]  <= w_sat_in;
            end
        end
    end

    assign o_quot = r_sat[STEPS] ? 16'hFFFF : r_quot[STEPS];

endmodule

`default_nettype wire

// ===== design/ppb_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module ppb_sqrt
    import ppb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [32:0] i_val,
    output logic      [16:0] o_root
);

    localparam int STEPS = 17;

    logic [33:0] r_val  [1:STEPS];
    logic [19:0] r_rem  [1:STEPS];
    logic [16:0] r_root [1:STEPS];

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [33:0] w_val_in;
        logic [19:0] w_rem_in;
        logic [16:0] w_root_in;
        logic [19:0] w_shift;
        logic [19:0] w_trial;
        logic        w_ge;
        if (k == 1) begin : g_first
            assign w_val_in  = {1'b0, i_val};
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_val_in  = r_val[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end
        assign w_shift = {w_rem_in[17:0], w_val_in[33:32]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_ge    = (w_shift >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k]  <= {w_val_in[31:0], 2'b00};
                r_rem[k]  <= w_ge ? (w_shift - w_trial) : w_shift;
                r_root[k] <= {w_root_in[15:0], w_ge};
            end
        end
    end

    assign o_root = r_root[STEPS];

endmodule

`default_nettype wire

// ===== design/plasma_pixel_blender_top.sv =====
// Top level of the plasma pixel blender: pixel pipeline, configuration and output queue.
`default_nettype none

// The block takes one pixel beat per clock while the output side keeps up.
// Each beat passes through the pipeline in order: an input register, a 16-stage
// divider for each of the x and y normalizations, a square and sum, a
// 17-stage square root for the radial term, then phase, sine lookup,
// intensity, ramp and blend stages, and the output queue register.
// Sustained rate is one pixel per clock while the output side keeps up.
// A two-entry output queue takes finished pixels while the consumer stalls,
// so input beats keep flowing until that queue is full; then the whole
// pipeline holds with nothing lost. The user must write frame width, height
// and time through the configuration port only while no pixel is in flight;
// the block itself does not enforce this. Widths and heights of zero count
// as one, and sizes above MAX_DIMENSION count as MAX_DIMENSION. The sine
// table holds SINE_TABLE_DEPTH entries over a full period and is built as
// constant logic at elaboration.

module plasma_pixel_blender_top
    import ppb_pkg::*;
#(
    parameter int MAX_DIMENSION    = MAX_DIMENSION_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [11:0] i_pixel_x,
    input  wire logic [11:0] i_pixel_y,
    input  wire logic [23:0] i_original_color,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [23:0] o_blended_color,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
    localparam int LAT      = 41;
    localparam int S_DIV    = 16;
    localparam int S_ROOT   = 35;

    // Configuration registers.
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [31:0] r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1024;
            r_height <= 13'd768;
            r_time   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                CFG_TIME:   r_time   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective divisors after clamping to the legal range.
    logic [12:0] w_den_x;
    logic [12:0] w_den_y;

    always_comb begin
        if (r_width == '0) begin
            w_den_x = 13'd1;
        end else if (32'(r_width) > MAX_DIMENSION) begin
            w_den_x = 13'(MAX_DIMENSION);
        end else begin
            w_den_x = r_width;
        end
        if (r_height == '0) begin
            w_den_y = 13'd1;
        end else if (32'(r_height) > MAX_DIMENSION) begin
            w_den_y = 13'(MAX_DIMENSION);
        end else begin
            w_den_y = r_height;
        end
    end

    // The pipeline advances as a whole while the output queue has room.
    logic [1:0]  r_cnt;
    logic        w_en;
    logic        w_push;
    logic        w_pop;

    assign w_en    = (r_cnt != 2'd2);
    assign o_ready = w_en;

    // Valid bits and the original colour travel along the pipeline.
    logic        r_vld  [0:LAT];
    logic [23:0] r_orig [0:LAT-1];
    logic [11:0] r_x;
    logic [11:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x       <= i_pixel_x;
            r_y       <= i_pixel_y;
            r_orig[0] <= i_original_color;
            for (int k = 1; k < LAT; k++) begin
                r_orig[k] <= r_orig[k-1];
            end
        end
    end

    // Normalized position, valid at the last divider stage.
    logic [15:0] w_nx;
    logic [15:0] w_ny;

    ppb_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_x),
        .i_den  (w_den_x),
        .o_quot (w_nx)
    );

    ppb_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_y),
        .i_den  (w_den_y),
        .o_quot (w_ny)
    );

    // Squares, then their sum, then the radius.
    logic [31:0] r_sq_x;
    logic [31:0] r_sq_y;
    logic [32:0] r_mag;
    logic [15:0] r_nx [S_DIV+1:S_ROOT];
    logic [15:0] r_ny [S_DIV+1:S_ROOT];
    logic [16:0] w_root;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x        <= 32'(w_nx) * 32'(w_nx);
            r_sq_y        <= 32'(w_ny) * 32'(w_ny);
            r_mag         <= 33'(r_sq_x) + 33'(r_sq_y);
            r_nx[S_DIV+1] <= w_nx;
            r_ny[S_DIV+1] <= w_ny;
            for (int k = S_DIV + 2; k <= S_ROOT; k++) begin
                r_nx[k] <= r_nx[k-1];
                r_ny[k] <= r_ny[k-1];
            end
        end
    end

    ppb_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_mag),
        .o_root (w_root)
    );

    // Phases in half-turns, Q16.16 modulo 2, so only 17 bits matter.
    logic [19:0] w_t3;
    logic [15:0] w_t1;
    logic [16:0] r_ph [4];

    assign w_t3 = ({2'b00, r_time[17:0]} << 1) + {2'b00, r_time[17:0]};
    assign w_t1 = r_time[15:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ph[0] <= 17'({r_nx[S_ROOT], 3'b000}) + {w_t1[15:0], 1'b0};
            r_ph[1] <= 17'(17'(r_ny[S_ROOT]) * 17'd6) + w_t3[17:1];
            r_ph[2] <= 17'((17'(r_nx[S_ROOT]) + 17'(r_ny[S_ROOT])) * 17'd10) + w_t3[16:0];
            r_ph[3] <= 17'(w_root * 17'd12) - {w_t1[14:0], 2'b00};
        end
    end

    // Full-period sine table, constant logic.
    logic signed [15:0] w_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] FRAC = (64'(k) << 32) / SINE_TABLE_DEPTH;
        localparam logic signed [15:0] VAL = sine_q15(FRAC);
        assign w_rom[k] = VAL;
    end

    logic signed [15:0] r_sin [4];

    for (genvar w = 0; w < 4; w++) begin : g_wave
        logic [29:0]      w_prod;
        logic [IDX_W-1:0] w_idx;
        assign w_prod = 30'(r_ph[w]) * 30'(SINE_TABLE_DEPTH);
        assign w_idx  = w_prod[17 +: IDX_W];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sin[w] <= w_rom[w_idx];
            end
        end
    end

    // Intensity: the wave sum offset by 4.0 and scaled to Q0.16.
    logic signed [18:0] w_sum;
    logic        [15:0] r_inten;

    assign w_sum = 19'(r_sin[0]) + 19'(r_sin[1]) + 19'(r_sin[2]) + 19'(r_sin[3])
                 + 19'sd131072;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inten <= w_sum[17:2];
        end
    end

    // Ramp segment and fraction within it.
    t_ramp_seg   r_seg;
    logic [16:0] r_frac;
    t_ramp_seg   w_seg;
    logic [16:0] w_frac;
    logic [17:0] w_over;

    always_comb begin
        w_over = '0;
        if (r_inten < RAMP_T1) begin
            w_seg  = SEG_LOW;
            w_frac = 17'(r_inten) * 17'd3;
        end else if (r_inten < RAMP_T2) begin
            w_seg  = SEG_MID;
            w_frac = 17'(r_inten - RAMP_T1) * 17'd3;
        end else begin
            w_seg  = SEG_HIGH;
            w_over = 18'(r_inten - RAMP_T2) * 18'd3;
            w_frac = (w_over > 18'(ONE_Q16)) ? ONE_Q16 : w_over[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_seg  <= w_seg;
            r_frac <= w_frac;
        end
    end

    // Ramp colour between the segment's end points.
    logic [23:0] w_ca;
    logic [23:0] w_cb;
    logic [23:0] r_ramp;

    always_comb begin
        unique case (r_seg)
            SEG_LOW: begin
                w_ca = COL_BLUE;
                w_cb = COL_CYAN;
            end
            SEG_MID: begin
                w_ca = COL_CYAN;
                w_cb = COL_YELLOW;
            end
            default: begin
                w_ca = COL_YELLOW;
                w_cb = COL_RED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_ramp[c*8 +: 8] <= blend_ch(w_ca[c*8 +: 8], w_cb[c*8 +: 8], r_frac);
            end
        end
    end

    // Final blend of the ramp colour over the original pixel.
    logic [23:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c*8 +: 8] <= blend_ch(r_orig[LAT-1][c*8 +: 8], r_ramp[c*8 +: 8],
                                            BLEND_80);
            end
        end
    end

    // Two-entry output queue; entry zero drives the output port.
    logic [23:0] r_q0;
    logic [23:0] r_q1;
    logic [1:0]  w_cnt_pop;

    assign w_push    = w_en && r_vld[LAT];
    assign w_pop     = (r_cnt != 2'd0) && i_ready;
    assign w_cnt_pop = r_cnt - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= w_cnt_pop + {1'b0, w_push};
        end
    end

    // A push into an empty slot zero wins over the shift from slot one.
    always_ff @(posedge i_clk) begin
        if (w_push && w_cnt_pop == 2'd0) begin
            r_q0 <= r_out;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
        if (w_push && w_cnt_pop == 2'd1) begin
            r_q1 <= r_out;
        end
    end

    assign o_valid         = (r_cnt != 2'd0);
    assign o_blended_color = r_q0;

    // The queue never holds more than two beats.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue overflow");

    // The queue count follows pushes and pops exactly.
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (3'(r_cnt) == 3'($past(r_cnt)) + 3'($past(w_push)) - 3'($past(w_pop))))
        else $error("output queue count mismatch");

    // A full queue with no pop freezes the pipeline tail.
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_ready) |=> $stable(r_vld[LAT]) && $stable(r_out))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== test/plasma_pixel_blender_top_test.sv =====
// Self-checking testbench for the plasma pixel blender: predicts each blended pixel and compares.
`timescale 1ns / 100ps

module plasma_pixel_blender_top_test
    import ppb_pkg::*;
;

    localparam int DIM_LIMIT  = 4096;
    localparam int SINE_DEPTH = 1024;
    localparam int LATENCY    = 43;

    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
        logic [23:0] color;
    } pixel_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [11:0] i_pixel_x = '0;
    logic [11:0] i_pixel_y = '0;
    logic [23:0] i_original_color = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [23:0] o_blended_color;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    plasma_pixel_blender_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_original_color(i_original_color),
        .o_valid(o_valid), .i_ready(i_ready), .o_blended_color(o_blended_color),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the frame registers, updated alongside every write.
    logic [12:0] width_reg = 13'd1024;
    logic [12:0] height_reg = 13'd768;
    logic [31:0] time_reg = 32'd0;

    // Sine table built once, the same way the hardware builds its constant table.
    int signed sine_tab [SINE_DEPTH];

    function automatic int signed sine_entry(input int k);
        longint unsigned f, a, a2, term, e;
        longint signed   sum;
        bit              neg;
        int              n;
        f = (longint'(k) << 32) / SINE_DEPTH;
        neg = 1'b0;
        if (f >= 64'h8000_0000) begin
            neg = 1'b1;
            f = f - 64'h8000_0000;
        end
        if (f > 64'h4000_0000) f = 64'h8000_0000 - f;
        a = (f * 64'd6746518852) >> 32;
        a2 = (a * a) >> 30;
        term = a;
        sum = a;
        for (n = 1; n <= 6; n++) begin
            term = ((term * a2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n & 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        e = ((longint'(sum) << 15) + (64'd1 << 29)) >> 30;
        if (e > 32767) e = 32767;
        return neg ? -int'(e) : int'(e);
    endfunction

    function automatic int signed wave(input logic [31:0] phase);
        longint unsigned idx;
        idx = (longint'(phase & 32'h1FFFF) * SINE_DEPTH) >> 17;
        return sine_tab[idx];
    endfunction

    function automatic logic [31:0] root_of(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] norm_pos(input logic [11:0] p, input logic [12:0] dim);
        longint unsigned d, q;
        d = 64'(dim);
        if (d == 0) d = 1;
        if (d > DIM_LIMIT) d = DIM_LIMIT;
        q = (longint'(p) << 16) / d;
        return (q > 65535) ? 32'hFFFF : q[31:0];
    endfunction

    function automatic logic [23:0] mix(input logic [23:0] a, input logic [23:0] b,
                                        input logic [31:0] f);
        logic [23:0]     res;
        longint unsigned c;
        int              sh;
        res = '0;
        for (sh = 0; sh < 24; sh += 8) begin
            c = (longint'((a >> sh) & 8'hFF) * (65536 - f)
                 + longint'((b >> sh) & 8'hFF) * f) >> 16;
            res = res | (24'(c & 8'hFF) << sh);
        end
        return res;
    endfunction

    function automatic logic [23:0] predict_blend(input pixel_t pix);
        logic [31:0] nx, ny, t, r, a1, a2, a3, a4, inten, f;
        int signed   s;
        logic [23:0] ramp_col;
        nx = norm_pos(pix.px, width_reg);
        ny = norm_pos(pix.py, height_reg);
        t = time_reg;
        r = root_of(longint'(nx) * nx + longint'(ny) * ny);
        a1 = nx * 8 + t * 2;
        a2 = ny * 6 + 32'((longint'(t) * 3) >> 1);
        a3 = (nx + ny) * 10 + t * 3;
        a4 = r * 12 - t * 4;
        s = wave(a1) + wave(a2) + wave(a3) + wave(a4);
        inten = 32'(s + 131072) >> 2;
        if (inten < 21627) begin
            ramp_col = mix(COL_BLUE, COL_CYAN, inten * 3);
        end else if (inten < 43254) begin
            ramp_col = mix(COL_CYAN, COL_YELLOW, (inten - 21627) * 3);
        end else begin
            // The last segment overshoots; clamp it at pure red.
            f = (inten - 43254) * 3;
            if (f > 65536) f = 65536;
            ramp_col = mix(COL_YELLOW, COL_RED, f);
        end
        return mix(pix.color, ramp_col, 52429);
    endfunction

    // Beats waiting to be driven, and blended colors waiting to come back.
    pixel_t      pending_pixels [$];
    logic [23:0] expected_colors [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    bit          in_taken = 1'b0;

    // Driver: presents the next pending pixel at the falling edge. A beat that is
    // offered stays put until the handshake takes it.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                // The beat just taken (if any) was predicted at the rising edge.
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    {i_pixel_x, i_pixel_y, i_original_color} <= pending_pixels.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts accepted input beats and checks accepted output beats.
    always @(posedge i_clk) begin
        logic [23:0] want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                expected_colors.push_back(
                    predict_blend('{i_pixel_x, i_pixel_y, i_original_color}));
            end
            if (o_valid && i_ready) begin
                if (expected_colors.size() == 0) begin
                    $error("blended_color: unexpected beat, actual %06h", o_blended_color);
                    error_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (o_blended_color !== want) begin
                        $error("blended_color: expected %06h, actual %06h",
                               want, o_blended_color);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg = value[12:0];
            CFG_HEIGHT: height_reg = value[12:0];
            default:    time_reg = value;
        endcase
    endtask

    // Wait until every queued pixel is sent and every blended color has returned.
    task automatic drain();
        while (pending_pixels.size() != 0 || i_valid || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count, input logic [12:0] w, input logic [12:0] h);
        pixel_t pix;
        repeat (count) begin
            // Mostly pixels inside the frame, some beyond it.
            if ($urandom_range(9) < 8) begin
                pix.px = 12'($urandom_range((w == 0) ? 0 : ((w > 4096) ? 4095 : w - 1)));
                pix.py = 12'($urandom_range((h == 0) ? 0 : ((h > 4096) ? 4095 : h - 1)));
            end else begin
                pix.px = 12'($urandom());
                pix.py = 12'($urandom());
            end
            pix.color = 24'($urandom());
            pending_pixels.push_back(pix);
        end
    endtask

    initial begin
        logic [12:0] w, h;
        int          ph;
        for (int k = 0; k < SINE_DEPTH; k++) sine_tab[k] = sine_entry(k);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels at reset settings: corners, edges, extreme colors.
        pending_pixels.push_back('{12'd0, 12'd0, 24'h000000});
        pending_pixels.push_back('{12'd1023, 12'd767, 24'hFFFFFF});
        pending_pixels.push_back('{12'd4095, 12'd4095, 24'hFFFFFF});
        pending_pixels.push_back('{12'd1024, 12'd0, 24'hFF0000});
        pending_pixels.push_back('{12'd0, 12'd768, 24'h00FF00});
        pending_pixels.push_back('{12'd512, 12'd384, 24'h0000FF});
        pending_pixels.push_back('{12'hAAA, 12'h555, 24'hAAAAAA});
        pending_pixels.push_back('{12'h555, 12'hAAA, 24'h555555});
        drain();

        // Degenerate and oversized frame sizes, wrapped time.
        write_reg(CFG_WIDTH, 32'd0);
        write_reg(CFG_HEIGHT, 32'h1FFF);
        write_reg(CFG_TIME, 32'hFFFF_FFFF);
        pending_pixels.push_back('{12'd0, 12'd0, 24'h123456});
        pending_pixels.push_back('{12'd1, 12'd4095, 24'hFEDCBA});
        pending_pixels.push_back('{12'd4095, 12'd2048, 24'h808080});
        drain();
        write_reg(CFG_WIDTH, 32'd4096);
        write_reg(CFG_HEIGHT, 32'd1);
        write_reg(CFG_TIME, 32'h0001_8000);
        pending_pixels.push_back('{12'd4095, 12'd0, 24'hFFFFFF});
        pending_pixels.push_back('{12'd2048, 12'd1, 24'h000000});
        // Sweep the x position across the frame at a fixed time.
        for (int k = 0; k < 8; k++) pending_pixels.push_back('{12'(k * 300), 12'd0, 24'h7F7F7F});
        drain();

        // Random phases: each picks new frame settings and an idling pattern.
        for (ph = 0; ph < 8; ph++) begin
            w = (ph == 0) ? 13'd4096 : (ph == 1) ? 13'd1 : 13'($urandom_range(8191));
            h = (ph == 2) ? 13'd4096 : (ph == 3) ? 13'd1 : 13'($urandom_range(8191));
            write_reg(CFG_WIDTH, 32'(w));
            write_reg(CFG_HEIGHT, 32'(h));
            write_reg(CFG_TIME, (ph == 4) ? 32'd0 : $urandom());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            queue_random(200, w, h);
            if (ph == 0) begin
                // Long receiver hold-off so the output queue fills and input stalls.
                recv_hold = 1'b1;
                repeat (150) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            drain();
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("plasma_pixel_blender_top_test: clean");
        end else begin
            $display("plasma_pixel_blender_top_test: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("plasma_pixel_blender_top_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ppb_pkg.sv
design/ppb_div.sv
design/ppb_sqrt.sv
design/plasma_pixel_blender_top.sv
test/plasma_pixel_blender_top_test.sv
